// ===== rtl/core/rotary_position_rotate_unit_assert.svh =====
// Assertion macros shared by the rotary position rotate unit.
// Both sample on the rising edge of clk and are off while rst is high.
`ifndef ROTARY_POSITION_ROTATE_UNIT_ASSERT_SVH
`define ROTARY_POSITION_ROTATE_UNIT_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define RPR_ASSERT_NOW(label, pre, post, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define RPR_ASSERT_NEXT(label, pre, post, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
    else $error(msg);

`endif

// ===== rtl/core/rpr_pkg.sv =====
package rpr_pkg;

  // Default sizes.
  localparam int HEAD_DIM_DEF      = 64;
  localparam int MAX_POSITIONS_DEF = 2048;

  // Register stages from input to output register.
  localparam int STAGES = 12;

  // Widths of the internal values.
  localparam int FREQ_W = 46;
  localparam int X_W    = 31;

  // Fixed-point constants.
  localparam logic [63:0] LOG2_TENK_Q32 = 64'd57070290109;
  localparam logic [63:0] INV_PI_Q32    = 64'd1367130551;
  localparam logic [30:0] HALF_PI_Q30   = 31'd1686629713;
  localparam logic [31:0] ONE_Q30       = 32'h4000_0000;

  // Reciprocals for exact floor division of a 32-bit value by small constants:
  // q = (x * ceil(2^S / D)) >> S with S = 32 + ceil(log2(D)).
  localparam int SH_110 = 39;
  localparam int SH_72  = 39;
  localparam int SH_42  = 38;
  localparam int SH_20  = 37;
  localparam int SH_6   = 35;
  localparam int SH_132 = 40;
  localparam int SH_90  = 39;
  localparam int SH_56  = 38;
  localparam int SH_30  = 37;
  localparam int SH_12  = 36;
  localparam logic [33:0] M_110 = 34'(((64'd1 << SH_110) + 64'd109) / 64'd110);
  localparam logic [33:0] M_72  = 34'(((64'd1 << SH_72) + 64'd71) / 64'd72);
  localparam logic [33:0] M_42  = 34'(((64'd1 << SH_42) + 64'd41) / 64'd42);
  localparam logic [33:0] M_20  = 34'(((64'd1 << SH_20) + 64'd19) / 64'd20);
  localparam logic [33:0] M_6   = 34'(((64'd1 << SH_6) + 64'd5) / 64'd6);
  localparam logic [33:0] M_132 = 34'(((64'd1 << SH_132) + 64'd131) / 64'd132);
  localparam logic [33:0] M_90  = 34'(((64'd1 << SH_90) + 64'd89) / 64'd90);
  localparam logic [33:0] M_56  = 34'(((64'd1 << SH_56) + 64'd55) / 64'd56);
  localparam logic [33:0] M_30  = 34'(((64'd1 << SH_30) + 64'd29) / 64'd30);
  localparam logic [33:0] M_12  = 34'(((64'd1 << SH_12) + 64'd11) / 64'd12);

  // Quadrant of the phase, taken from its top two bits.
  typedef enum logic [1:0] {
    QUAD_I   = 2'd0,
    QUAD_II  = 2'd1,
    QUAD_III = 2'd2,
    QUAD_IV  = 2'd3
  } quad_t;

  // Values that ride along the pipeline beside the angle arithmetic.
  typedef struct packed {
    quad_t              quad;
    logic signed [15:0] first_value;
    logic signed [15:0] second_value;
  } side_t;

  // Floor integer square root, one result bit per step.
  function automatic logic [63:0] isqrt64(input logic [63:0] n_in);
    logic [63:0] n;
    logic [63:0] res;
    logic [63:0] bitv;
    n    = n_in;
    res  = '0;
    bitv = 64'h4000_0000_0000_0000;
    for (int i = 0; i < 32; i++) begin
      if (n >= res + bitv) begin
        n   = n - (res + bitv);
        res = (res >> 1) + bitv;
      end else begin
        res = res >> 1;
      end
      bitv = bitv >> 2;
    end
    return res;
  endfunction

  // Frequency table entry for exponent e (Q32): 2^-e radians per position,
  // in turns, Q48. Evaluated at elaboration only.
  function automatic logic [63:0] freq_entry(input logic [63:0] e);
    logic [63:0] roots [33];
    logic [63:0] whole;
    logic [31:0] frac;
    logic [63:0] acc;
    roots[0] = 64'd1 << 31;
    for (int k = 1; k <= 32; k++) begin
      roots[k] = isqrt64(roots[k-1] << 32);
    end
    whole = e >> 32;
    frac  = e[31:0];
    acc   = 64'd1 << 32;
    for (int k = 1; k <= 32; k++) begin
      if (frac[32-k]) begin
        acc = (acc * roots[k] + (64'd1 << 31)) >> 32;
      end
    end
    acc = (whole < 64'd63) ? (acc >> whole) : 64'd0;
    return (acc * INV_PI_Q32) >> 17;
  endfunction

  // Floor of x divided by a constant, through its reciprocal.
  function automatic logic [31:0] div_magic(input logic [31:0] x, input logic [33:0] m,
                                            input int sh);
    logic [65:0] p;
    p = {34'd0, x} * {32'd0, m};
    return 32'(p >> sh);
  endfunction

  // Truncating Q30 product.
  function automatic logic [31:0] mul_q30(input logic [31:0] a, input logic [31:0] b);
    logic [63:0] p;
    p = {32'd0, a} * {32'd0, b};
    return p[61:30];
  endfunction

  // One Horner step: 1 - q * t.
  function automatic logic [31:0] horner(input logic [31:0] q, input logic [31:0] t);
    return ONE_Q30 - mul_q30(q, t);
  endfunction

  // Q30 to Q1.14, rounded, clamped to zero and one.
  function automatic logic [14:0] to_q14(input logic signed [33:0] v);
    logic [33:0] r;
    r = ($unsigned(v) + 34'd32768) >> 16;
    if (v < 0) begin
      return 15'd0;
    end
    return (r > 34'd16384) ? 15'd16384 : r[14:0];
  endfunction

endpackage

// ===== rtl/core/rpr_in_if.sv =====
interface rpr_in_if;
  logic               valid;
  logic               ready;
  logic [10:0]        position;
  logic [4:0]         pair_index;
  logic signed [15:0] first_value;
  logic signed [15:0] second_value;

  modport source (output valid, position, pair_index, first_value, second_value,
                  input ready);
  modport sink (input valid, position, pair_index, first_value, second_value,
                output ready);
endinterface

// ===== rtl/core/rpr_out_if.sv =====
interface rpr_out_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] first_rotated;
  logic signed [15:0] second_rotated;

  modport source (output valid, first_rotated, second_rotated, input ready);
  modport sink (input valid, first_rotated, second_rotated, output ready);
endinterface

// ===== rtl/core/rpr_phase.sv =====
module rpr_phase #(
  parameter int HEAD_DIM      = rpr_pkg::HEAD_DIM_DEF,
  parameter int MAX_POSITIONS = rpr_pkg::MAX_POSITIONS_DEF
) (
  input  logic                      clk,
  input  logic [2:0]                en,
  input  logic [10:0]               position,
  input  logic [4:0]                pair_index,
  input  logic signed [15:0]        first_value,
  input  logic signed [15:0]        second_value,
  output logic [rpr_pkg::X_W-1:0]   x,
  output rpr_pkg::side_t            side
);

  localparam int PAIRS = HEAD_DIM / 2;
  localparam int ROM_N = (PAIRS < 32) ? PAIRS : 32;
  localparam int IW    = (ROM_N > 1) ? $clog2(ROM_N) : 1;

  // Frequency per pair, fixed at elaboration.
  logic [rpr_pkg::FREQ_W-1:0] rom [ROM_N];

  for (genvar g = 0; g < ROM_N; g++) begin : g_rom
    localparam logic [63:0] EXP_Q32 = (64'(2 * g) * rpr_pkg::LOG2_TENK_Q32) / HEAD_DIM;
    assign rom[g] = rpr_pkg::FREQ_W'(rpr_pkg::freq_entry(EXP_Q32));
  end

  logic [10:0]                 pos_cl;
  logic [4:0]                  j_cl;
  logic [rpr_pkg::FREQ_W-1:0]  freq;
  logic [10:0]                 pos;
  rpr_pkg::side_t              side0;
  logic [rpr_pkg::FREQ_W+10:0] phase_prod;
  logic [31:0]                 phase;
  rpr_pkg::side_t              side1;
  logic [60:0]                 x_prod;

  // Clamp position and pair index into range.
  always_comb begin
    pos_cl = position;
    if ({6'd0, position} >= 17'(MAX_POSITIONS)) begin
      pos_cl = 11'(MAX_POSITIONS - 1);
    end
    j_cl = pair_index;
    if ({27'd0, pair_index} >= 32'(ROM_N)) begin
      j_cl = 5'(ROM_N - 1);
    end
  end

  // Stage 0: table lookup.
  always_ff @(posedge clk) begin
    if (en[0]) begin
      freq  <= rom[j_cl[IW-1:0]];
      pos   <= pos_cl;
      side0 <= '{quad: rpr_pkg::QUAD_I, first_value: first_value,
                 second_value: second_value};
    end
  end

  // Stage 1: phase in turns.
  assign phase_prod = {11'd0, freq} * {{rpr_pkg::FREQ_W{1'b0}}, pos};

  always_ff @(posedge clk) begin
    if (en[1]) begin
      phase <= phase_prod[47:16];
      side1 <= side0;
    end
  end

  // Stage 2: angle within the quadrant, in radians Q30.
  assign x_prod = {31'd0, phase[29:0]} * {30'd0, rpr_pkg::HALF_PI_Q30};

  always_ff @(posedge clk) begin
    if (en[2]) begin
      x    <= x_prod[60:30];
      side <= '{quad: rpr_pkg::quad_t'(phase[31:30]), first_value: side1.first_value,
                second_value: side1.second_value};
    end
  end

endmodule

// ===== rtl/core/rpr_sincos.sv =====
module rpr_sincos (
  input  logic                    clk,
  input  logic [6:0]              en,
  input  logic [rpr_pkg::X_W-1:0] x,
  input  rpr_pkg::side_t          side,
  output logic [14:0]             cos_q,
  output logic [14:0]             sin_q,
  output rpr_pkg::side_t          side_out
);

  // Angle and its square.
  logic [61:0]    sq_prod;
  logic [31:0]    x3, x4, x5, x6, x7, x8;
  logic [31:0]    x2;
  rpr_pkg::side_t sd3, sd4, sd5, sd6, sd7, sd8;

  // Quotients of the square by the series constants.
  logic [31:0] q72_4, q42_4, q20_4, q6_4, q90_4, q56_4, q30_4, q12_4, q2_4;
  logic [31:0] q42_5, q20_5, q6_5, q56_5, q30_5, q12_5, q2_5;
  logic [31:0] q20_6, q6_6, q30_6, q12_6, q2_6;
  logic [31:0] q6_7, q12_7, q2_7;
  logic [31:0] q2_8;

  // Horner terms for sine and cosine.
  logic [31:0] ts4, ts5, ts6, ts7, ts8;
  logic [31:0] tc4, tc5, tc6, tc7, tc8;

  logic signed [33:0] cos_raw;

  assign sq_prod = {31'd0, x} * {31'd0, x};

  // Stage 3: square of the angle.
  always_ff @(posedge clk) begin
    if (en[0]) begin
      x2  <= sq_prod[61:30];
      x3  <= {1'b0, x};
      sd3 <= side;
    end
  end

  // Stage 4: all quotients, first Horner term.
  always_ff @(posedge clk) begin
    if (en[1]) begin
      ts4   <= rpr_pkg::ONE_Q30 - rpr_pkg::div_magic(x2, rpr_pkg::M_110, rpr_pkg::SH_110);
      tc4   <= rpr_pkg::ONE_Q30 - rpr_pkg::div_magic(x2, rpr_pkg::M_132, rpr_pkg::SH_132);
      q72_4 <= rpr_pkg::div_magic(x2, rpr_pkg::M_72, rpr_pkg::SH_72);
      q42_4 <= rpr_pkg::div_magic(x2, rpr_pkg::M_42, rpr_pkg::SH_42);
      q20_4 <= rpr_pkg::div_magic(x2, rpr_pkg::M_20, rpr_pkg::SH_20);
      q6_4  <= rpr_pkg::div_magic(x2, rpr_pkg::M_6, rpr_pkg::SH_6);
      q90_4 <= rpr_pkg::div_magic(x2, rpr_pkg::M_90, rpr_pkg::SH_90);
      q56_4 <= rpr_pkg::div_magic(x2, rpr_pkg::M_56, rpr_pkg::SH_56);
      q30_4 <= rpr_pkg::div_magic(x2, rpr_pkg::M_30, rpr_pkg::SH_30);
      q12_4 <= rpr_pkg::div_magic(x2, rpr_pkg::M_12, rpr_pkg::SH_12);
      q2_4  <= x2 >> 1;
      x4    <= x3;
      sd4   <= sd3;
    end
  end

  // Stage 5: second Horner term.
  always_ff @(posedge clk) begin
    if (en[2]) begin
      ts5   <= rpr_pkg::horner(q72_4, ts4);
      tc5   <= rpr_pkg::horner(q90_4, tc4);
      q42_5 <= q42_4;
      q20_5 <= q20_4;
      q6_5  <= q6_4;
      q56_5 <= q56_4;
      q30_5 <= q30_4;
      q12_5 <= q12_4;
      q2_5  <= q2_4;
      x5    <= x4;
      sd5   <= sd4;
    end
  end

  // Stage 6: third Horner term.
  always_ff @(posedge clk) begin
    if (en[3]) begin
      ts6   <= rpr_pkg::horner(q42_5, ts5);
      tc6   <= rpr_pkg::horner(q56_5, tc5);
      q20_6 <= q20_5;
      q6_6  <= q6_5;
      q30_6 <= q30_5;
      q12_6 <= q12_5;
      q2_6  <= q2_5;
      x6    <= x5;
      sd6   <= sd5;
    end
  end

  // Stage 7: fourth Horner term.
  always_ff @(posedge clk) begin
    if (en[4]) begin
      ts7   <= rpr_pkg::horner(q20_6, ts6);
      tc7   <= rpr_pkg::horner(q30_6, tc6);
      q6_7  <= q6_6;
      q12_7 <= q12_6;
      q2_7  <= q2_6;
      x7    <= x6;
      sd7   <= sd6;
    end
  end

  // Stage 8: fifth Horner term.
  always_ff @(posedge clk) begin
    if (en[5]) begin
      ts8  <= rpr_pkg::horner(q6_7, ts7);
      tc8  <= rpr_pkg::horner(q12_7, tc7);
      q2_8 <= q2_7;
      x8   <= x7;
      sd8  <= sd7;
    end
  end

  // Stage 9: final products, converted to Q1.14.
  assign cos_raw = $signed({2'b0, rpr_pkg::ONE_Q30})
                 - $signed({2'b0, rpr_pkg::mul_q30(q2_8, tc8)});

  always_ff @(posedge clk) begin
    if (en[6]) begin
      sin_q    <= rpr_pkg::to_q14($signed({2'b0, rpr_pkg::mul_q30(x8, ts8)}));
      cos_q    <= rpr_pkg::to_q14(cos_raw);
      side_out <= sd8;
    end
  end

endmodule

// ===== rtl/core/rpr_mix.sv =====
module rpr_mix (
  input  logic               clk,
  input  logic [1:0]         en,
  input  logic [14:0]        cos_q,
  input  logic [14:0]        sin_q,
  input  rpr_pkg::side_t     side,
  output logic signed [15:0] first_rotated,
  output logic signed [15:0] second_rotated
);

  logic signed [15:0] cos_base, sin_base;
  logic signed [15:0] cos_v, sin_v;
  logic signed [31:0] p_ac, p_bs, p_bc, p_as;
  logic signed [32:0] sum_first, sum_second;

  assign cos_base = $signed({1'b0, cos_q});
  assign sin_base = $signed({1'b0, sin_q});

  // Apply quadrant signs and swaps.
  always_comb begin
    case (side.quad)
      rpr_pkg::QUAD_I: begin
        cos_v = cos_base;
        sin_v = sin_base;
      end
      rpr_pkg::QUAD_II: begin
        cos_v = -sin_base;
        sin_v = cos_base;
      end
      rpr_pkg::QUAD_III: begin
        cos_v = -cos_base;
        sin_v = -sin_base;
      end
      default: begin
        cos_v = sin_base;
        sin_v = -cos_base;
      end
    endcase
  end

  // Stage 10: the four products.
  always_ff @(posedge clk) begin
    if (en[0]) begin
      p_ac <= side.first_value * cos_v;
      p_bs <= side.second_value * sin_v;
      p_bc <= side.second_value * cos_v;
      p_as <= side.first_value * sin_v;
    end
  end

  assign sum_first  = 33'(p_ac) - 33'(p_bs) + 33'sd8192;
  assign sum_second = 33'(p_bc) + 33'(p_as) + 33'sd8192;

  // Round to Q4.11 and saturate.
  function automatic logic signed [15:0] round_sat(input logic signed [32:0] s);
    logic signed [32:0] r;
    r = s >>> 14;
    if (r > 33'sd32767) begin
      return 16'sh7FFF;
    end
    if (r < -33'sd32768) begin
      return 16'sh8000;
    end
    return r[15:0];
  endfunction

  // Stage 11: output register.
  always_ff @(posedge clk) begin
    if (en[1]) begin
      first_rotated  <= round_sat(sum_first);
      second_rotated <= round_sat(sum_second);
    end
  end

endmodule

// ===== rtl/core/rotary_position_rotate_unit.sv =====
// Rotary position embedding, rotate-half form.
// The pair channel takes one item per cycle unless the full pipeline stalls:
// a token position, a pair index j and elements j and j + HEAD_DIM/2 of a
// query or key row (signed Q4.11). The result channel returns one item per
// pair item, in order: the pair rotated by the angle position *
// 10000^(-2j/HEAD_DIM), rounded and saturated to signed Q4.11. Out-of-range
// positions and pair indexes are clamped to the last valid value.
// Each item passes through the twelve register stages: table lookup, phase
// multiply, radian scaling, square, series quotients, four Horner steps, final
// products, rotation products and output rounding.
// Each stage holds a valid bit. A stage loads whenever it is empty or the
// stage after it moves, so bubbles are squeezed out while the receiver
// stalls, and the pair channel stops only when all stages are full.
// Reset (rst, synchronous) empties the pipeline; the frequency table is
// constant and needs no fill time.
module rotary_position_rotate_unit #(
  parameter int HEAD_DIM      = rpr_pkg::HEAD_DIM_DEF,
  parameter int MAX_POSITIONS = rpr_pkg::MAX_POSITIONS_DEF
) (
  input logic       clk,
  input logic       rst,
  rpr_in_if.sink    pair,
  rpr_out_if.source result
);

  localparam int LAST = rpr_pkg::STAGES - 1;

  logic [rpr_pkg::STAGES-1:0] valid;
  logic [rpr_pkg::STAGES-1:0] en;

  logic [rpr_pkg::X_W-1:0] x;
  rpr_pkg::side_t          side_a, side_b;
  logic [14:0]             cos_q, sin_q;

  // A stage may load when it is empty or its item moves on.
  always_comb begin
    en[LAST] = !valid[LAST] || result.ready;
    for (int i = LAST - 1; i >= 0; i--) begin
      en[i] = !valid[i] || en[i+1];
    end
  end

  // Valid bits travel with the items.
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
    end else begin
      if (en[0]) begin
        valid[0] <= pair.valid;
      end
      for (int i = 1; i <= LAST; i++) begin
        if (en[i]) begin
          valid[i] <= valid[i-1];
        end
      end
    end
  end

  assign pair.ready   = en[0];
  assign result.valid = valid[LAST];

  rpr_phase #(
    .HEAD_DIM      (HEAD_DIM),
    .MAX_POSITIONS (MAX_POSITIONS)
  ) u_phase (
    .clk          (clk),
    .en           (en[2:0]),
    .position     (pair.position),
    .pair_index   (pair.pair_index),
    .first_value  (pair.first_value),
    .second_value (pair.second_value),
    .x            (x),
    .side         (side_a)
  );

  rpr_sincos u_sincos (
    .clk      (clk),
    .en       (en[9:3]),
    .x        (x),
    .side     (side_a),
    .cos_q    (cos_q),
    .sin_q    (sin_q),
    .side_out (side_b)
  );

  rpr_mix u_mix (
    .clk            (clk),
    .en             (en[11:10]),
    .cos_q          (cos_q),
    .sin_q          (sin_q),
    .side           (side_b),
    .first_rotated  (result.first_rotated),
    .second_rotated (result.second_rotated)
  );

`include "rotary_position_rotate_unit_assert.svh"

  `RPR_ASSERT_NOW(a_full_stall_blocks, (&valid) && !result.ready, !pair.ready,
    "pair channel ready while the pipeline is full and stalled")
  `RPR_ASSERT_NEXT(a_stalled_result_kept, valid[LAST] && !result.ready, valid[LAST],
    "stalled result item dropped")
  `RPR_ASSERT_NEXT(a_accept_enters, pair.valid && pair.ready, valid[0],
    "accepted item did not enter the first stage")
  `RPR_ASSERT_NOW(a_empty_after_reset, $past(rst), valid == '0,
    "pipeline not empty after reset")

endmodule
